// File: rtl/dik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_pkg
// Shared widths, register codes, angle constants and the arctangent table
// of the delta inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package dik_pkg;

  localparam int LEG_COUNT_DEF = 3;
  localparam int REG_COUNT     = 8;
  localparam int CFG_W         = 31;
  localparam int CFG_IDX_W     = 4;
  localparam int POS_W         = 32;
  localparam int ANG_W         = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_UPPER    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LOWER    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANG  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANG  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_AZ_FIRST = CFG_IDX_W'(5);

  localparam logic [CFG_W-1:0] CFG_RST [REG_COUNT] = '{
    31'd1677722, 31'd1677722, 31'd3355443, 31'd1725826220,
    31'd421657428, 31'd0, 31'd562209905, 31'd1124419810
  };

  // extended angle width, Q3.28 with headroom for wrap
  localparam int ANGX_W = 34;
  localparam logic signed [ANGX_W-1:0] K_HALF_PI = ANGX_W'(421657428);
  localparam logic signed [ANGX_W-1:0] K_PI      = ANGX_W'(843314857);
  localparam logic signed [ANGX_W-1:0] K_TWO_PI  = ANGX_W'(1686629713);
  localparam logic signed [ANGX_W-1:0] K_FOUR_PI = K_TWO_PI <<< 1;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_START = 652032874;
  localparam int ROT_W        = 33;
  localparam int VEC_W        = 36;
  localparam int VZ_W         = 32;
  localparam int SQ_W         = 63;
  localparam int SQ_STEPS     = 32;
  localparam int ROOT_W       = 31;

  localparam logic signed [VZ_W-1:0] ARC_TAB [CORDIC_STEPS] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
    32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
    32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192,
    32'sd4096, 32'sd2048, 32'sd1024, 32'sd512,
    32'sd256, 32'sd128, 32'sd64, 32'sd32,
    32'sd16, 32'sd8, 32'sd4, 32'sd2
  };

  localparam int ROT_LAT  = CORDIC_STEPS + 2;
  localparam int TERM_LAT = 9;
  localparam int VEC_LAT  = CORDIC_STEPS + 1;
  localparam int WRAP_LAT = 3;
  localparam int LEG_LAT  = ROT_LAT + TERM_LAT + SQ_STEPS + 1 + VEC_LAT + WRAP_LAT;

  typedef struct packed {
    logic [CFG_W-1:0]        radius;
    logic [CFG_W-1:0]        upper;
    logic [CFG_W-1:0]        lower;
    logic signed [CFG_W-1:0] min_ang;
    logic signed [CFG_W-1:0] max_ang;
    logic [CFG_W-1:0]        azimuth;
  } leg_cfg_t;

  typedef struct packed {
    logic             ok;
    logic [ANG_W-1:0] angle;
  } leg_res_t;

endpackage
`default_nettype wire

// File: rtl/dik_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_if
// Request channels of the inverse kinematics block: target and joint result.
// ----------------------------------------------------------------------------
interface dik_in_if import dik_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] target_x;
  logic signed [POS_W-1:0] target_y;
  logic signed [POS_W-1:0] target_z;

  modport source (output valid, output target_x, output target_y, output target_z,
                  input ready);
  modport sink (input valid, input target_x, input target_y, input target_z,
                output ready);
endinterface

interface dik_out_if import dik_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] joint_angle_first;
  logic signed [ANG_W-1:0] joint_angle_second;
  logic signed [ANG_W-1:0] joint_angle_third;
  logic                    reachable;

  modport source (output valid, output joint_angle_first, output joint_angle_second,
                  output joint_angle_third, output reachable, input ready);
  modport sink (input valid, input joint_angle_first, input joint_angle_second,
                input joint_angle_third, input reachable, output ready);
endinterface
`default_nettype wire

// File: rtl/dik_cordic_rot.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_cordic_rot
// Pipelined rotation CORDIC: cosine and sine of a leg azimuth in Q.30.
// ----------------------------------------------------------------------------
module dik_cordic_rot
  import dik_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [CFG_W-1:0]        azimuth,
  output logic signed [ROT_W-1:0] cos_q30,
  output logic signed [ROT_W-1:0] sin_q30
);

  logic signed [ANGX_W-1:0] g_mod;
  logic signed [ANGX_W-1:0] g_wrap;
  logic signed [ANGX_W-1:0] g_fold;
  logic                     flip;

  logic signed [ROT_W-1:0]  x_r    [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0]  y_r    [CORDIC_STEPS+1];
  logic signed [ANGX_W-1:0] g_r    [CORDIC_STEPS+1];
  logic                     flip_r [CORDIC_STEPS+1];
  logic signed [ROT_W-1:0]  cos_r;
  logic signed [ROT_W-1:0]  sin_r;

  always_comb begin
    g_mod = $signed(ANGX_W'(azimuth));
    if (g_mod >= K_TWO_PI) begin
      g_mod = g_mod - K_TWO_PI;
    end
    g_wrap = (g_mod > K_PI) ? g_mod - K_TWO_PI : g_mod;
    flip   = 1'b0;
    g_fold = g_wrap;
    if (g_wrap > K_HALF_PI) begin
      g_fold = g_wrap - K_PI;
      flip   = 1'b1;
    end else if (g_wrap < -K_HALF_PI) begin
      g_fold = g_wrap + K_PI;
      flip   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= ROT_W'(CORDIC_START);
      y_r[0]    <= '0;
      g_r[0]    <= g_fold;
      flip_r[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [ROT_W-1:0] xs;
    logic signed [ROT_W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (g_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          g_r[i+1] <= g_r[i] - ANGX_W'(ARC_TAB[i]);
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          g_r[i+1] <= g_r[i] + ANGX_W'(ARC_TAB[i]);
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      sin_r <= flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    end
  end

  assign cos_q30 = cos_r;
  assign sin_q30 = sin_r;

endmodule
`default_nettype wire

// File: rtl/dik_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dik_isqrt
  import dik_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [SQ_W-1:0]   rad,
  output logic [ROOT_W-1:0] root
);

  logic [SQ_W-1:0] n_r   [SQ_STEPS];
  logic [SQ_W-1:0] res_r [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 1 - 2 * i);
    logic [SQ_W-1:0] n_in;
    logic [SQ_W-1:0] res_in;
    logic [SQ_W-1:0] sum;
    if (i == 0) begin : g_first
      assign n_in   = rad;
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[i-1];
      assign res_in = res_r[i-1];
    end
    assign sum = res_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= sum) begin
          n_r[i]   <= n_in - sum;
          res_r[i] <= (res_in >> 1) + BIT;
        end else begin
          n_r[i]   <= n_in;
          res_r[i] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res_r[SQ_STEPS-1][ROOT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/dik_cordic_vec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_cordic_vec
// Pipelined vectoring CORDIC: atan2(y, x) in Q3.28.
// ----------------------------------------------------------------------------
module dik_cordic_vec
  import dik_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [31:0]     x_in,
  input  logic signed [32:0]     y_in,
  output logic signed [VZ_W-1:0] angle
);

  logic signed [VEC_W-1:0] xe;
  logic signed [VEC_W-1:0] ye;
  logic signed [VEC_W-1:0] x0;
  logic signed [VEC_W-1:0] y0;
  logic signed [VZ_W-1:0]  z0;

  logic signed [VEC_W-1:0] x_r    [CORDIC_STEPS+1];
  logic signed [VEC_W-1:0] y_r    [CORDIC_STEPS+1];
  logic signed [VZ_W-1:0]  z_r    [CORDIC_STEPS+1];
  logic                    zero_r [CORDIC_STEPS+1];

  always_comb begin
    xe = VEC_W'(x_in);
    ye = VEC_W'(y_in);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = VZ_W'(K_HALF_PI);
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -VZ_W'(K_HALF_PI);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= (xe == 0) && (ye == 0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ARC_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ARC_TAB[i];
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign angle = zero_r[CORDIC_STEPS] ? '0 : z_r[CORDIC_STEPS];

endmodule
`default_nettype wire

// File: rtl/dik_leg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_leg
// One leg lane: azimuth trig, G/E/F terms, normalize, radicand, root,
// two atan2 solutions, wrap into the joint range and selection.
// ----------------------------------------------------------------------------
module dik_leg
  import dik_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [POS_W-1:0] px,
  input  logic signed [POS_W-1:0] py,
  input  logic signed [POS_W-1:0] pz,
  input  leg_cfg_t                cfg,
  output leg_res_t                res
);

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

  function automatic logic signed [ANGX_W-1:0] wrap_mod(input logic signed [ANGX_W-1:0] d);
    logic signed [ANGX_W-1:0] m;
    if (d < -K_TWO_PI) begin
      m = d + K_FOUR_PI;
    end else if (d < 0) begin
      m = d + K_TWO_PI;
    end else if (d < K_TWO_PI) begin
      m = d;
    end else begin
      m = d - K_TWO_PI;
    end
    return m;
  endfunction

  // trig and target delay
  logic signed [ROT_W-1:0] cos_q30;
  logic signed [ROT_W-1:0] sin_q30;
  logic signed [POS_W-1:0] px_r [ROT_LAT];
  logic signed [POS_W-1:0] py_r [ROT_LAT];
  logic signed [POS_W-1:0] pz_r [ROT_LAT];

  dik_cordic_rot u_rot (
    .clk     (clk),
    .en      (en),
    .azimuth (cfg.azimuth),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      px_r[0] <= px;
      py_r[0] <= py;
      pz_r[0] <= pz;
      for (int k = 1; k < ROT_LAT; k++) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
        pz_r[k] <= pz_r[k-1];
      end
    end
  end

  // products
  logic signed [POS_W-1:0] xd, yd, zd;
  logic [31:0] mx, my, mz, mc, ms;
  logic [63:0] p_xc, p_ys, p_xx, p_yy, p_zz;
  logic [61:0] p_rr, p_lpp, p_ldd;
  logic [62:0] p_zl;
  logic signed [34:0] xc_nxt, ys_nxt;
  logic signed [40:0] f1_nxt;

  assign xd = px_r[ROT_LAT-1];
  assign yd = py_r[ROT_LAT-1];
  assign zd = pz_r[ROT_LAT-1];

  always_comb begin
    mx    = xd[31] ? 32'(-xd) : 32'(xd);
    my    = yd[31] ? 32'(-yd) : 32'(yd);
    mz    = zd[31] ? 32'(-zd) : 32'(zd);
    mc    = cos_q30[ROT_W-1] ? 32'(-cos_q30) : 32'(cos_q30);
    ms    = sin_q30[ROT_W-1] ? 32'(-sin_q30) : 32'(sin_q30);
    p_xc  = mx * mc;
    p_ys  = my * ms;
    p_xx  = mx * mx;
    p_yy  = my * my;
    p_zz  = mz * mz;
    p_rr  = cfg.radius * cfg.radius;
    p_lpp = cfg.upper * cfg.upper;
    p_ldd = cfg.lower * cfg.lower;
    p_zl  = mz * cfg.upper;
    xc_nxt = $signed({1'b0, p_xc[63:30]});
    if (xd[31] != cos_q30[ROT_W-1]) begin
      xc_nxt = -xc_nxt;
    end
    ys_nxt = $signed({1'b0, p_ys[63:30]});
    if (yd[31] != sin_q30[ROT_W-1]) begin
      ys_nxt = -ys_nxt;
    end
    f1_nxt = $signed({1'b0, p_zl[62:23]});
    if (zd[31]) begin
      f1_nxt = -f1_nxt;
    end
  end

  logic signed [34:0] xc_r, ys_r;
  logic [39:0] xx_r, yy_r, zz_r;
  logic [37:0] rr_r, lpp_r, ldd_r;
  logic signed [40:0] f1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xc_r  <= xc_nxt;
      ys_r  <= ys_nxt;
      xx_r  <= p_xx[63:24];
      yy_r  <= p_yy[63:24];
      zz_r  <= p_zz[63:24];
      rr_r  <= p_rr[61:24];
      lpp_r <= p_lpp[61:24];
      ldd_r <= p_ldd[61:24];
      f1_r  <= f1_nxt;
    end
  end

  // sums
  logic signed [35:0] u_nxt;
  logic signed [36:0] rmu_nxt;
  logic signed [47:0] sq_nxt;
  logic signed [35:0] u2_r;
  logic signed [36:0] rmu2_r;
  logic signed [47:0] sq2_r;
  logic signed [40:0] f2_r;

  always_comb begin
    u_nxt   = 36'(xc_r) + 36'(ys_r);
    rmu_nxt = 37'($signed({1'b0, cfg.radius})) - 37'(u_nxt);
    sq_nxt  = $signed(48'(xx_r) + 48'(yy_r) + 48'(zz_r) + 48'(rr_r) + 48'(lpp_r)
                      - 48'(ldd_r));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_r   <= u_nxt;
      rmu2_r <= rmu_nxt;
      sq2_r  <= sq_nxt;
      f2_r   <= f1_r;
    end
  end

  // r*u and E
  logic [33:0] mu, mrmu;
  logic [64:0] p_ru, p_e;
  logic signed [42:0] ru_nxt, e_nxt;
  logic signed [42:0] ru3_r, e3_r;
  logic signed [47:0] sq3_r;
  logic signed [40:0] f3_r;

  always_comb begin
    mu     = u2_r[35] ? 34'(-u2_r) : 34'(u2_r);
    mrmu   = rmu2_r[36] ? 34'(-rmu2_r) : 34'(rmu2_r);
    p_ru   = mu * cfg.radius;
    p_e    = mrmu * cfg.upper;
    ru_nxt = $signed({1'b0, p_ru[64:23]});
    if (u2_r[35]) begin
      ru_nxt = -ru_nxt;
    end
    e_nxt = $signed({1'b0, p_e[64:23]});
    if (rmu2_r[36]) begin
      e_nxt = -e_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ru3_r <= ru_nxt;
      e3_r  <= e_nxt;
      sq3_r <= sq2_r;
      f3_r  <= f2_r;
    end
  end

  // G
  logic signed [47:0] g4_r, e4_r, f4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g4_r <= sq3_r - 48'(ru3_r);
      e4_r <= 48'(e3_r);
      f4_r <= 48'(f3_r);
    end
  end

  // largest magnitude
  logic [47:0] mg5, me5, mf5, big_nxt;
  logic [47:0] big5_r;
  logic signed [47:0] g5_r, e5_r, f5_r;

  always_comb begin
    mg5     = mag48(g4_r);
    me5     = mag48(e4_r);
    mf5     = mag48(f4_r);
    big_nxt = mg5;
    if (me5 > big_nxt) begin
      big_nxt = me5;
    end
    if (mf5 > big_nxt) begin
      big_nxt = mf5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big5_r <= big_nxt;
      g5_r   <= g4_r;
      e5_r   <= e4_r;
      f5_r   <= f4_r;
    end
  end

  // shift count so that every magnitude drops below 2^30
  logic [4:0] n_nxt;
  logic [4:0] n6_r;
  logic signed [47:0] g6_r, e6_r, f6_r;

  always_comb begin
    n_nxt = '0;
    for (int k = 30; k < 48; k++) begin
      if (big5_r[k]) begin
        n_nxt = 5'(k - 29);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n6_r <= n_nxt;
      g6_r <= g5_r;
      e6_r <= e5_r;
      f6_r <= f5_r;
    end
  end

  // normalize
  logic [47:0] gsh, esh, fsh;
  logic signed [30:0] g7_nxt, e7_nxt, f7_nxt;
  logic signed [30:0] g7_r, e7_r, f7_r;

  always_comb begin
    gsh    = mag48(g6_r) >> n6_r;
    esh    = mag48(e6_r) >> n6_r;
    fsh    = mag48(f6_r) >> n6_r;
    g7_nxt = $signed({1'b0, gsh[29:0]});
    e7_nxt = $signed({1'b0, esh[29:0]});
    f7_nxt = $signed({1'b0, fsh[29:0]});
    if (g6_r[47]) begin
      g7_nxt = -g7_nxt;
    end
    if (e6_r[47]) begin
      e7_nxt = -e7_nxt;
    end
    if (f6_r[47]) begin
      f7_nxt = -f7_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g7_r <= g7_nxt;
      e7_r <= e7_nxt;
      f7_r <= f7_nxt;
    end
  end

  // squares
  logic [29:0] mg7, me7, mf7;
  logic [59:0] ff8_r, ee8_r, gg8_r;
  logic signed [31:0] den8_r;
  logic signed [30:0] f8_r;

  always_comb begin
    mg7 = g7_r[30] ? 30'(-g7_r) : 30'(g7_r);
    me7 = e7_r[30] ? 30'(-e7_r) : 30'(e7_r);
    mf7 = f7_r[30] ? 30'(-f7_r) : 30'(f7_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ff8_r  <= mf7 * mf7;
      ee8_r  <= me7 * me7;
      gg8_r  <= mg7 * mg7;
      den8_r <= 32'(g7_r) - 32'(e7_r);
      f8_r   <= f7_r;
    end
  end

  // radicand
  logic signed [SQ_W-1:0] rad9_r;
  logic signed [31:0] den9_r;
  logic signed [30:0] f9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad9_r <= $signed(SQ_W'(ff8_r) + SQ_W'(ee8_r) - SQ_W'(gg8_r));
      den9_r <= den8_r;
      f9_r   <= f8_r;
    end
  end

  // root
  logic [SQ_W-1:0]   sq_in;
  logic [ROOT_W-1:0] root;
  logic signed [30:0] fq_r   [SQ_STEPS];
  logic signed [31:0] denq_r [SQ_STEPS];
  logic               negq_r [SQ_STEPS];

  assign sq_in = rad9_r[SQ_W-1] ? '0 : $unsigned(rad9_r);

  dik_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq_in),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fq_r[0]   <= f9_r;
      denq_r[0] <= den9_r;
      negq_r[0] <= rad9_r[SQ_W-1];
      for (int k = 1; k < SQ_STEPS; k++) begin
        fq_r[k]   <= fq_r[k-1];
        denq_r[k] <= denq_r[k-1];
        negq_r[k] <= negq_r[k-1];
      end
    end
  end

  // atan2 operands
  logic signed [32:0] ya_r, yb_r;
  logic signed [31:0] xd_r;
  logic               negc_r;
  logic signed [32:0] root_s;

  assign root_s = 33'($signed({1'b0, root}));

  always_ff @(posedge clk) begin
    if (en) begin
      ya_r   <= 33'(fq_r[SQ_STEPS-1]) + root_s;
      yb_r   <= 33'(fq_r[SQ_STEPS-1]) - root_s;
      xd_r   <= denq_r[SQ_STEPS-1];
      negc_r <= negq_r[SQ_STEPS-1];
    end
  end

  logic signed [VZ_W-1:0] za, zb;
  logic                   negv_r [VEC_LAT];

  dik_cordic_vec u_vec_a (
    .clk   (clk),
    .en    (en),
    .x_in  (xd_r),
    .y_in  (ya_r),
    .angle (za)
  );

  dik_cordic_vec u_vec_b (
    .clk   (clk),
    .en    (en),
    .x_in  (xd_r),
    .y_in  (yb_r),
    .angle (zb)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      negv_r[0] <= negc_r;
      for (int k = 1; k < VEC_LAT; k++) begin
        negv_r[k] <= negv_r[k-1];
      end
    end
  end

  // wrap and select
  logic signed [ANGX_W-1:0] lo, hi;
  logic signed [ANGX_W-1:0] da_r, db_r, aa_r, ab_r;
  logic                     negd1_r, negd2_r;
  logic                     ok_a, ok_b;
  leg_res_t                 res_nxt;
  leg_res_t                 res_r;

  assign lo = ANGX_W'(cfg.min_ang);
  assign hi = ANGX_W'(cfg.max_ang);

  always_ff @(posedge clk) begin
    if (en) begin
      da_r    <= (ANGX_W'(za) <<< 1) - lo;
      db_r    <= (ANGX_W'(zb) <<< 1) - lo;
      negd1_r <= negv_r[VEC_LAT-1];
      aa_r    <= wrap_mod(da_r) + lo;
      ab_r    <= wrap_mod(db_r) + lo;
      negd2_r <= negd1_r;
    end
  end

  always_comb begin
    ok_a = (aa_r >= lo) && (aa_r <= hi);
    ok_b = (ab_r >= lo) && (ab_r <= hi);
    res_nxt.ok = !negd2_r && (ok_a || ok_b);
    if (ok_a && ok_b) begin
      res_nxt.angle = (aa_r < ab_r) ? ANG_W'(aa_r) : ANG_W'(ab_r);
    end else if (ok_a) begin
      res_nxt.angle = ANG_W'(aa_r);
    end else begin
      res_nxt.angle = ANG_W'(ab_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// File: rtl/delta_inverse_kinematics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_inverse_kinematics
// Delta robot inverse kinematics: tool target to three joint angles.
// ----------------------------------------------------------------------------
// Targets (Q7.24) come in on in_ch, joint angles (Q3.28) and a reachable
// flag leave on out_ch; both use valid/ready, a request moves when both are
// high. Geometry and joint limits sit in eight registers on the cfg_ write
// port; the user must write them only while no request is in flight.
// Each leg runs in its own lane: targets wait 30 stages beside a rotation
// CORDIC for the azimuth, then nine stages of products, sums and
// normalization, a 32-stage square root, one stage of atan2 operands, two
// 29-stage vectoring CORDICs and three stages of wrap and selection.
// The block itself does not enforce that rule. An output register follows the
// lanes; one target is taken every cycle while in_ch.ready is high.
// The whole pipeline advances together; it holds only when its last stage
// and the output register are both full and out_ch.ready is low, so a result
// waiting at the output does not stop new targets while the last stage is
// empty. Reset clears the valid bits and loads the default geometry.
// ----------------------------------------------------------------------------
module delta_inverse_kinematics
  import dik_pkg::*;
#(
  parameter int LEG_COUNT = LEG_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dik_in_if.sink               in_ch,
  dik_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] cfg_r [REG_COUNT];
  logic [LEG_LAT-1:0] v_r;
  logic adv;
  logic out_v_r;
  logic reach_r;
  logic [ANG_W-1:0] ang_r [LEG_COUNT];
  leg_res_t res [LEG_COUNT];
  logic reach;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < REG_COUNT; k++) begin
        cfg_r[k] <= CFG_RST[k];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
      cfg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  assign adv         = !v_r[LEG_LAT-1] || !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LEG_LAT-2:0], in_ch.valid};
    end
  end

  for (genvar l = 0; l < LEG_COUNT; l++) begin : g_leg
    leg_cfg_t lcfg;
    assign lcfg.radius  = cfg_r[REG_RADIUS[2:0]];
    assign lcfg.upper   = cfg_r[REG_UPPER[2:0]];
    assign lcfg.lower   = cfg_r[REG_LOWER[2:0]];
    assign lcfg.min_ang = $signed(cfg_r[REG_MIN_ANG[2:0]]);
    assign lcfg.max_ang = $signed(cfg_r[REG_MAX_ANG[2:0]]);
    assign lcfg.azimuth = cfg_r[REG_AZ_FIRST[2:0] + 3'(l)];

    dik_leg u_leg (
      .clk (clk),
      .en  (adv),
      .px  (in_ch.target_x),
      .py  (in_ch.target_y),
      .pz  (in_ch.target_z),
      .cfg (lcfg),
      .res (res[l])
    );
  end

  always_comb begin
    reach = 1'b1;
    for (int l = 0; l < LEG_COUNT; l++) begin
      reach = reach && res[l].ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && v_r[LEG_LAT-1]) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v_r[LEG_LAT-1]) begin
      reach_r <= reach;
      for (int l = 0; l < LEG_COUNT; l++) begin
        ang_r[l] <= reach ? res[l].angle : '0;
      end
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.reachable          = reach_r;
  assign out_ch.joint_angle_first  = $signed(ang_r[0]);
  assign out_ch.joint_angle_second = $signed(ang_r[1]);
  assign out_ch.joint_angle_third  = $signed(ang_r[2]);

endmodule
`default_nettype wire

// File: rtl/dik_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_checker
// Port-level checks of the inverse kinematics block, bound to the top level.
// ----------------------------------------------------------------------------
module dik_checker
  import dik_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ANG_W-1:0] j_first,
  input logic [ANG_W-1:0] j_second,
  input logic [ANG_W-1:0] j_third,
  input logic             reach
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reach |-> (j_first == '0) && (j_second == '0) && (j_third == '0))
    else $error("unreachable result with nonzero angles");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind delta_inverse_kinematics dik_checker u_dik_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .j_first   (out_ch.joint_angle_first),
  .j_second  (out_ch.joint_angle_second),
  .j_third   (out_ch.joint_angle_third),
  .reach     (out_ch.reachable)
);
`default_nettype wire

// File: sim/tb_delta_inverse_kinematics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_inverse_kinematics
// Self-checking regression of the delta robot inverse kinematics block.
// ----------------------------------------------------------------------------
// Drives tool targets through several geometry settings and handshake
// pressures. A bit-accurate joint solver predicts each result. Every
// delivered request is compared field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_delta_inverse_kinematics;
  import dik_pkg::*;

  localparam longint TWO_PI_Q = 1686629713;
  localparam longint PI_Q     = 843314857;
  localparam longint HALF_PI_Q = 421657428;
  localparam longint ONE_M    = 64'sd16777216;
  localparam int     CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [POS_W-1:0] x, y, z;
  } target_t;

  typedef struct {
    logic signed [ANG_W-1:0] ang0, ang1, ang2;
    logic                    reach;
  } joints_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dik_in_if  in_ch ();
  dik_out_if out_ch ();

  delta_inverse_kinematics dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  logic [CFG_W-1:0] geom [REG_COUNT];
  target_t pending_targets [$];
  joints_t expected_joints [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.target_z = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < REG_COUNT; i++) geom[i] = CFG_RST[i];
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint mul_sh(longint a, longint b, int sh);
    longint unsigned p;
    longint r;
    p = (mag(a) * mag(b)) >> sh;
    r = longint'(p);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint trunc_sh(longint v, int n);
    longint r;
    r = longint'(mag(v) >> n);
    return v < 0 ? -r : r;
  endfunction

  function automatic void rotate_azimuth(longint ang, output longint c, output longint s);
    longint g, x, y, xs, ys;
    bit flip;
    g = ang % TWO_PI_Q;
    x = CORDIC_START;
    y = 0;
    flip = 0;
    if (g > PI_Q) g -= TWO_PI_Q;
    if (g > HALF_PI_Q) begin
      g -= PI_Q;
      flip = 1;
    end else if (g < -HALF_PI_Q) begin
      g += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (g >= 0) begin
        x -= ys; y += xs; g -= longint'(ARC_TAB[i]);
      end else begin
        x += ys; y -= xs; g += longint'(ARC_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ARC_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(ARC_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint wrap_to(longint a, longint lo);
    longint m;
    m = (a - lo) % TWO_PI_Q;
    if (m < 0) m += TWO_PI_Q;
    return m + lo;
  endfunction

  function automatic bit leg_angle(longint px, longint py, longint pz, int leg,
                                   output longint angle);
    longint r, lp, ld, lo, hi, c, s, u, g, e, f, rad, root, den, a1, a2;
    longint unsigned big;
    int n;
    bit ok1, ok2;
    r = longint'(geom[0]);
    lp = longint'(geom[1]);
    ld = longint'(geom[2]);
    lo = longint'($signed(geom[3]));
    hi = longint'($signed(geom[4]));
    angle = 0;
    rotate_azimuth(longint'(geom[5 + leg]), c, s);
    u = mul_sh(px, c, 30) + mul_sh(py, s, 30);
    g = mul_sh(px, px, 24) + mul_sh(py, py, 24) + mul_sh(pz, pz, 24)
        + mul_sh(r, r, 24) + mul_sh(lp, lp, 24) - mul_sh(ld, ld, 24)
        - mul_sh(r, u, 23);
    e = mul_sh(lp, r - u, 23);
    f = mul_sh(pz, lp, 23);
    big = mag(g);
    if (mag(e) > big) big = mag(e);
    if (mag(f) > big) big = mag(f);
    n = 0;
    while ((big >> n) >= 64'd1073741824) n++;
    g = trunc_sh(g, n);
    e = trunc_sh(e, n);
    f = trunc_sh(f, n);
    rad = f * f + e * e - g * g;
    if (rad < 0) return 0;
    root = longint'(floor_root(longint'(rad)));
    den = g - e;
    a1 = wrap_to(2 * vector_angle(f + root, den), lo);
    a2 = wrap_to(2 * vector_angle(f - root, den), lo);
    ok1 = a1 >= lo && a1 <= hi;
    ok2 = a2 >= lo && a2 <= hi;
    if (ok1 && ok2) angle = a1 < a2 ? a1 : a2;
    else if (ok1) angle = a1;
    else if (ok2) angle = a2;
    else return 0;
    return 1;
  endfunction

  function automatic joints_t solve_joints(target_t t);
    joints_t j;
    longint ang [3];
    bit reach;
    reach = 1;
    for (int leg = 0; leg < 3; leg++) begin
      ang[leg] = 0;
      if (reach && !leg_angle(longint'(t.x), longint'(t.y), longint'(t.z), leg, ang[leg]))
        reach = 0;
    end
    j.ang0 = reach ? ANG_W'(ang[0]) : '0;
    j.ang1 = reach ? ANG_W'(ang[1]) : '0;
    j.ang2 = reach ? ANG_W'(ang[2]) : '0;
    j.reach = reach;
    return j;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_targets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        target_t t;
        t = pending_targets.pop_front();
        in_ch.target_x <= t.x;
        in_ch.target_y <= t.y;
        in_ch.target_z <= t.z;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      target_t t;
      t.x = in_ch.target_x;
      t.y = in_ch.target_y;
      t.z = in_ch.target_z;
      expected_joints.insert(expected_joints.size(), solve_joints(t));
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_joints.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result request at cycle %0d", cycles);
        end else begin
          joints_t e;
          e = expected_joints.pop_front();
          if (out_ch.joint_angle_first !== e.ang0 || out_ch.joint_angle_second !== e.ang1
              || out_ch.joint_angle_third !== e.ang2 || out_ch.reachable !== e.reach) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d %0d %0d r%0b got %0d %0d %0d r%0b",
                       e.ang0, e.ang1, e.ang2, e.reach, out_ch.joint_angle_first,
                       out_ch.joint_angle_second, out_ch.joint_angle_third,
                       out_ch.reachable);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("delta_inverse_kinematics regression: fail");
      $finish;
    end
  end

  task automatic write_reg(int idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= val;
    if (idx < REG_COUNT) geom[idx] = val;
  endtask

  task automatic load_geometry(logic [CFG_W-1:0] r, logic [CFG_W-1:0] lp,
                               logic [CFG_W-1:0] ld, logic [CFG_W-1:0] lo,
                               logic [CFG_W-1:0] hi, logic [CFG_W-1:0] a0,
                               logic [CFG_W-1:0] a1, logic [CFG_W-1:0] a2);
    write_reg(REG_RADIUS, r);
    write_reg(REG_UPPER, lp);
    write_reg(REG_LOWER, ld);
    write_reg(REG_MIN_ANG, lo);
    write_reg(REG_MAX_ANG, hi);
    write_reg(REG_AZ_FIRST, a0);
    write_reg(REG_AZ_FIRST + 1, a1);
    write_reg(REG_AZ_FIRST + 2, a2);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_targets.size() > 0 || in_ch.valid || expected_joints.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_target(longint x, longint y, longint z);
    target_t t;
    t.x = POS_W'(x);
    t.y = POS_W'(y);
    t.z = POS_W'(z);
    pending_targets.insert(pending_targets.size(), t);
  endtask

  // mostly targets inside the working volume, some raw noise
  task automatic add_random_targets(int count);
    longint span, reach;
    for (int i = 0; i < count; i++) begin
      span = longint'(geom[2]) + longint'(geom[1]) + 1;
      if ($urandom_range(99) < 20 || span > 64'sd1000000000) begin
        add_target($signed($urandom), $signed($urandom), $signed($urandom));
      end else begin
        reach = span * 2 / 3 + 1;
        add_target(longint'($urandom_range(32'(2 * reach))) - reach,
                   longint'($urandom_range(32'(2 * reach))) - reach,
                   -longint'($urandom_range(32'(span))));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase: reset geometry rewritten, no idling
    write_reg(9, 31'h7FFFFFFF);
    load_geometry(CFG_RST[0], CFG_RST[1], CFG_RST[2], CFG_RST[3], CFG_RST[4],
                  CFG_RST[5], CFG_RST[6], CFG_RST[7]);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_target(0, 0, 0);
    add_target(0, 0, -(ONE_M / 5));
    add_target(0, 0, -(ONE_M / 4));
    add_target(ONE_M / 20, -(ONE_M / 20), -(ONE_M / 5));
    add_target(-(ONE_M / 20), ONE_M / 30, -(ONE_M * 3 / 10));
    add_target(0, 0, ONE_M / 5);
    add_target(ONE_M, ONE_M, ONE_M);
    add_target(64'sh7FFFFFFF, 64'sh7FFFFFFF, 64'sh7FFFFFFF);
    add_target(-64'sh80000000, -64'sh80000000, -64'sh80000000);
    add_target(64'sh7FFFFFFF, -64'sh80000000, 0);
    add_target(-64'sh80000000, 0, 64'sh7FFFFFFF);
    add_target(-1, -1, -1);
    add_target(1, 0, -1);
    add_target(0, ONE_M / 10, -(ONE_M / 5));
    add_random_targets(280);
    wait_drained();

    // phase: wide joint limits, larger arms, sender idle
    load_geometry(31'd2516582, 31'd4194304, 31'd8388608, 31'(-PI_Q), 31'(PI_Q),
                  31'd1686629713, 31'd562209905, 31'd1124419810);
    send_idle_pct = 59;
    recv_stall_pct = 0;
    add_random_targets(300);
    wait_drained();

    // phase: register extremes, receiver stalls
    load_geometry(31'h7FFFFFFF, 31'h0, 31'h7FFFFFFF, 31'h40000000, 31'h3FFFFFFF,
                  31'h7FFFFFFF, 31'h0, 31'h55555555);
    send_idle_pct = 0;
    recv_stall_pct = 59;
    add_random_targets(20);
    wait_drained();
    load_geometry(31'h0, 31'h7FFFFFFF, 31'h0, 31'(-PI_Q), 31'(PI_Q),
                  31'h2AAAAAAA, 31'h7FFFFFFF, 31'h0);
    add_random_targets(20);
    wait_drained();
    load_geometry(31'd1677722, 31'd3355443, 31'd5033165, 31'h0, 31'(PI_Q),
                  31'd100000, 31'd700000000, 31'd1300000000);
    add_random_targets(260);
    wait_drained();

    // phase: random geometry, both sides idle
    send_idle_pct = 16;
    recv_stall_pct = 16;
    for (int k = 0; k < 6; k++) begin
      load_geometry(31'($urandom_range(6000000)), 31'($urandom_range(8000000)),
                    31'($urandom_range(12000000)),
                    31'(-longint'($urandom_range(843314857))),
                    31'($urandom_range(843314857)),
                    31'($urandom), 31'($urandom), 31'($urandom));
      add_random_targets(50);
      wait_drained();
    end

    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_joints.size() == 0) begin
      $display("delta_inverse_kinematics regression: pass");
    end else begin
      $display("delta_inverse_kinematics regression: fail");
    end
    $finish;
  end

endmodule
